FILE: rtl/datagram_reassembly_tracker_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef DATAGRAM_REASSEMBLY_TRACKER_MACROS_SVH
`define DATAGRAM_REASSEMBLY_TRACKER_MACROS_SVH
`ifndef SYNTH
`define DRT_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");
`define DRT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define DRT_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define DRT_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/drt_pkg.sv
package drt_pkg;

  localparam int MAX_DATAGRAM = 2048;
  localparam int HEADER_BYTES = 17;
  localparam int ID_SLOTS     = 16;
  localparam int MAX_SEQ      = 1024;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  localparam int POS_W   = $clog2(MAX_DATAGRAM + 1);
  localparam int CNT_W   = $clog2(MAX_SEQ + 1);
  localparam int SEQ_W   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
  localparam int SLOT_W  = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int BM_BITS = ID_SLOTS * MAX_SEQ;
  localparam int BIT_W   = (BM_BITS > 64) ? $clog2(BM_BITS) : 6;
  localparam int BM_WORD_W = 32;
  localparam int OFF_W   = 5;
  localparam int BM_WORDS  = (BM_BITS + BM_WORD_W - 1) / BM_WORD_W;
  localparam int ADDR_W  = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] total;
    logic [63:0] id;
    logic [31:0] crc;
  } req_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/drt_front.sv
module drt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [7:0]        put_type_i,
  output logic              req_push_o,
  output drt_pkg::req_t     req_o
);

  logic [drt_pkg::POS_W-1:0] pos_q, pos_d;
  logic [31:0] crc_q, crc_d, crc_upd;
  logic [31:0] seq_q, seq_d, total_q, total_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] id_q, id_d;
  logic        in_range;
  logic [drt_pkg::POS_W-1:0] len;
  logic [drt_pkg::POS_W-1:0] id_off;

  assign in_range = (pos_q < drt_pkg::POS_W'(drt_pkg::MAX_DATAGRAM));
  assign crc_upd  = drt_pkg::crc_byte(crc_q, data_byte_i);
  assign id_off   = pos_q - drt_pkg::POS_W'(9);
  assign len      = in_range ? pos_q + drt_pkg::POS_W'(1) : pos_q;

  always_comb begin
    seq_d   = seq_q;
    total_d = total_q;
    type_d  = type_q;
    id_d    = id_q;
    if (in_range) begin
      if (pos_q < drt_pkg::POS_W'(4)) begin
        seq_d[8*pos_q[1:0] +: 8] = data_byte_i;
      end else if (pos_q < drt_pkg::POS_W'(8)) begin
        total_d[8*pos_q[1:0] +: 8] = data_byte_i;
      end else if (pos_q == drt_pkg::POS_W'(8)) begin
        type_d = data_byte_i;
      end else if (pos_q < drt_pkg::POS_W'(drt_pkg::HEADER_BYTES)) begin
        id_d[8*id_off[2:0] +: 8] = data_byte_i;
      end
    end
    crc_d = in_range ? crc_upd : crc_q;
    pos_d = len;
    if (last_byte_i) begin
      crc_d = 32'hFFFF_FFFF;
      pos_d = '0;
    end
  end

  assign req_push_o = accept_i && last_byte_i
                   && (len >= drt_pkg::POS_W'(drt_pkg::HEADER_BYTES))
                   && (type_d == put_type_i)
                   && (seq_d < 32'(drt_pkg::MAX_SEQ));

  always_comb begin
    req_o.seq   = seq_d;
    req_o.total = total_d;
    req_o.id    = id_d;
    req_o.crc   = ~(in_range ? crc_upd : crc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= 32'hFFFF_FFFF;
      seq_q   <= '0;
      total_q <= '0;
      type_q  <= '0;
      id_q    <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      seq_q   <= seq_d;
      total_q <= total_d;
      type_q  <= type_d;
      id_q    <= id_d;
    end
  end

endmodule

FILE: rtl/drt_req_fifo.sv
module drt_req_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  drt_pkg::req_t data_i,
  input  logic          pop_i,
  output drt_pkg::req_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  drt_pkg::req_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: rtl/drt_back.sv
module drt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_empty_i,
  input  drt_pkg::req_t req_i,
  output logic          req_pop_o,
  output logic          clearing_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [31:0]   ack_seq_o,
  output logic [10:0]   ack_count_o,
  output logic [63:0]   file_id_o,
  output logic [31:0]   ack_crc_o,
  output logic          status_o,
  output logic          file_complete_o
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_UPDATE} state_e;

  state_e state_q;
  drt_pkg::req_t req_q;
  logic [drt_pkg::ADDR_W-1:0] clr_q;
  logic out_valid_q;

  logic [drt_pkg::ID_SLOTS-1:0] slot_valid_q;
  logic [63:0] slot_id_q    [drt_pkg::ID_SLOTS];
  logic [31:0] slot_total_q [drt_pkg::ID_SLOTS];
  logic [drt_pkg::CNT_W-1:0] slot_count_q [drt_pkg::ID_SLOTS];

  logic [drt_pkg::BM_WORD_W-1:0] bm_mem [drt_pkg::BM_WORDS];
  logic [drt_pkg::BM_WORD_W-1:0] rdata_q;

  logic hit, free;
  logic [drt_pkg::SLOT_W-1:0] hit_idx, free_idx, sel_idx, slot_q;
  logic [drt_pkg::BIT_W-1:0]  bit_idx;
  logic [drt_pkg::ADDR_W-1:0] rd_addr, addr_q;
  logic [drt_pkg::OFF_W-1:0]  off_q;
  logic mismatch_q;
  logic alloc;
  logic inc;
  logic [drt_pkg::CNT_W-1:0] new_cnt;
  logic mem_we;
  logic [drt_pkg::ADDR_W-1:0] mem_waddr;
  logic [drt_pkg::BM_WORD_W-1:0] mem_wdata;

  // Lowest matching slot wins, as does the lowest free one.
  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = drt_pkg::ID_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && (slot_id_q[i] == req_q.id)) begin
        hit = 1'b1;
        hit_idx = drt_pkg::SLOT_W'(i);
      end
      if (!slot_valid_q[i]) begin
        free = 1'b1;
        free_idx = drt_pkg::SLOT_W'(i);
      end
    end
  end

  assign sel_idx = hit ? hit_idx : free_idx;
  assign alloc   = (state_q == S_LOOK) && !hit && free;
  assign bit_idx = drt_pkg::BIT_W'(sel_idx) * drt_pkg::BIT_W'(drt_pkg::MAX_SEQ)
                 + drt_pkg::BIT_W'(req_q.seq[drt_pkg::SEQ_W-1:0]);
  assign rd_addr = drt_pkg::ADDR_W'(bit_idx >> drt_pkg::OFF_W);

  assign inc     = !mismatch_q && !rdata_q[off_q];
  assign new_cnt = slot_count_q[slot_q] + drt_pkg::CNT_W'(inc);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = rdata_q | (drt_pkg::BM_WORD_W'(1) << off_q);
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_UPDATE: begin
        mem_we = inc;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bm_mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_LOOK) begin
      rdata_q <= bm_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc) begin
      slot_id_q[free_idx]    <= req_q.id;
      slot_total_q[free_idx] <= req_q.total;
      slot_count_q[free_idx] <= '0;
    end
    if (state_q == S_UPDATE) begin
      slot_count_q[slot_q] <= new_cnt;
    end
  end

  assign req_pop_o  = (state_q == S_IDLE) && !req_empty_i && !out_valid_q;
  assign clearing_o = (state_q == S_CLEAR);
  assign empty_o    = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      clr_q           <= '0;
      out_valid_q     <= 1'b0;
      slot_valid_q    <= '0;
      req_q           <= '0;
      slot_q          <= '0;
      addr_q          <= '0;
      off_q           <= '0;
      mismatch_q      <= 1'b0;
      ack_seq_o       <= '0;
      ack_count_o     <= '0;
      file_id_o       <= '0;
      ack_crc_o       <= '0;
      status_o        <= 1'b0;
      file_complete_o <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + drt_pkg::ADDR_W'(1);
          if (clr_q == drt_pkg::ADDR_W'(drt_pkg::BM_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_pop_o) begin
            req_q   <= req_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!hit && !free) begin
            state_q <= S_IDLE;
          end else begin
            if (alloc) begin
              slot_valid_q[free_idx] <= 1'b1;
            end
            slot_q     <= sel_idx;
            addr_q     <= rd_addr;
            off_q      <= bit_idx[drt_pkg::OFF_W-1:0];
            mismatch_q <= hit && (slot_total_q[hit_idx] != req_q.total);
            state_q    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          out_valid_q     <= 1'b1;
          ack_seq_o       <= req_q.seq;
          ack_count_o     <= new_cnt;
          file_id_o       <= req_q.id;
          ack_crc_o       <= req_q.crc;
          status_o        <= mismatch_q;
          file_complete_o <= !mismatch_q && (32'(new_cnt) == req_q.total);
          state_q         <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/datagram_reassembly_tracker.sv
// Takes one datagram byte per cycle while full is low, with no gaps required
// between datagrams. A front stage runs CRC-32C and captures the header; each
// datagram that passes its length, type and sequence checks becomes one request
// in a two-entry queue. The table stage handles a request in three steps
// (dequeue, slot lookup with bitmap read, bitmap update); it starts a request
// only once the previous acknowledgement has been popped, and full rises while
// two requests wait behind it. After reset the sequence bitmap memory is
// cleared one 32-bit word per cycle, 512 words in all, and full stays high
// while it is cleared.
`include "datagram_reassembly_tracker_macros.svh"

module datagram_reassembly_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] ack_seq_o,
  output logic [10:0] ack_count_o,
  output logic [63:0] file_id_o,
  output logic [31:0] ack_crc_o,
  output logic        status_o,
  output logic        file_complete_o
);

  logic [7:0] put_type_q;
  logic accept;
  logic req_push, req_pop, req_full, req_empty, clearing;
  drt_pkg::req_t req_in, req_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      put_type_q <= '0;
    end else if (cfg_we_i) begin
      put_type_q <= cfg_wdata_i;
    end
  end

  assign full   = req_full || clearing;
  assign accept = push && !full;

  drt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .put_type_i  (put_type_q),
    .req_push_o  (req_push),
    .req_o       (req_in)
  );

  drt_req_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .data_i  (req_in),
    .pop_i   (req_pop),
    .data_o  (req_out),
    .full_o  (req_full),
    .empty_o (req_empty)
  );

  drt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_empty_i     (req_empty),
    .req_i           (req_out),
    .req_pop_o       (req_pop),
    .clearing_o      (clearing),
    .empty_o         (empty),
    .pop_i           (pop),
    .ack_seq_o       (ack_seq_o),
    .ack_count_o     (ack_count_o),
    .file_id_o       (file_id_o),
    .ack_crc_o       (ack_crc_o),
    .status_o        (status_o),
    .file_complete_o (file_complete_o)
  );

  `DRT_ASSERT_IMPLY(a_complete_stored, clk_i, rst_ni, !empty && file_complete_o, !status_o)
  `DRT_ASSERT_IMPLY(a_stored_counted, clk_i, rst_ni, !empty && !status_o, ack_count_o != 11'd0)
  `DRT_ASSERT_IMPLY(a_count_range, clk_i, rst_ni, !empty, ack_count_o <= 11'(drt_pkg::MAX_SEQ))
  `DRT_ASSERT_IMPLY(a_clear_blocks, clk_i, rst_ni, clearing, full)

endmodule

FILE: tb/datagram_reassembly_tracker_checker.sv
`timescale 1ns / 100ps

module datagram_reassembly_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] ack_seq_o,
  input  logic [10:0] ack_count_o,
  input  logic [63:0] file_id_o,
  input  logic [31:0] ack_crc_o,
  input  logic        status_o,
  input  logic        file_complete_o,
  output int          fail_count,
  output int          pending_acks
);

  typedef struct packed {
    logic [31:0] seq;
    logic [10:0] count;
    logic [63:0] id;
    logic [31:0] crc;
    logic        status;
    logic        complete;
  } ack_t;

  ack_t        ack_q[$];
  logic [7:0]  put_code;
  int unsigned pos;
  logic [31:0] crc;
  logic [31:0] h_seq, h_total;
  logic [7:0]  h_type;
  logic [63:0] h_id;
  logic        sv_valid[drt_pkg::ID_SLOTS];
  logic [63:0] sv_id[drt_pkg::ID_SLOTS];
  logic [31:0] sv_total[drt_pkg::ID_SLOTS];
  logic [10:0] sv_count[drt_pkg::ID_SLOTS];
  logic        seen[drt_pkg::ID_SLOTS * drt_pkg::MAX_SEQ];

  function automatic logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] b);
    c ^= {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
    return c;
  endfunction

  // Table update at the end of a datagram; queues an ack if one is due.
  task automatic close_datagram();
    int   slot;
    bit   hit;
    ack_t a;
    slot = 0;
    hit = 0;
    if (pos < drt_pkg::HEADER_BYTES || h_type != put_code || h_seq >= drt_pkg::MAX_SEQ) return;
    for (int i = 0; i < drt_pkg::ID_SLOTS && !hit; i++)
      if (sv_valid[i] && sv_id[i] == h_id) begin
        slot = i;
        hit = 1;
      end
    if (!hit) begin
      for (int i = 0; i < drt_pkg::ID_SLOTS && !hit; i++)
        if (!sv_valid[i]) begin
          slot = i;
          hit = 1;
        end
      if (!hit) return;
      sv_valid[slot] = 1;
      sv_id[slot] = h_id;
      sv_total[slot] = h_total;
      sv_count[slot] = 0;
    end
    a.status = 0;
    a.complete = 0;
    if (sv_total[slot] != h_total) a.status = 1;
    else begin
      if (!seen[slot * drt_pkg::MAX_SEQ + h_seq]) begin
        seen[slot * drt_pkg::MAX_SEQ + h_seq] = 1;
        sv_count[slot]++;
      end
      a.complete = ({21'd0, sv_count[slot]} == h_total);
    end
    a.seq = h_seq;
    a.count = sv_count[slot];
    a.id = h_id;
    a.crc = ~crc;
    ack_q.push_back(a);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ack_t e;
    if (!rst_ni) begin
      put_code <= 8'd0;
      pos = 0;
      crc = '1;
      h_seq = 0;
      h_total = 0;
      h_type = 0;
      h_id = 0;
      fail_count = 0;
      ack_q.delete();
      for (int i = 0; i < drt_pkg::ID_SLOTS; i++) begin
        sv_valid[i] = 0;
        sv_count[i] = 0;
      end
      foreach (seen[i]) seen[i] = 0;
    end else begin
      if (!empty && pop) begin
        if (ack_q.size() == 0) begin
          $error("ack with no request outstanding");
          fail_count++;
        end else begin
          e = ack_q.pop_front();
          if (ack_seq_o !== e.seq) begin
            $error("ack_seq exp %0h got %0h", e.seq, ack_seq_o); fail_count++;
          end
          if (ack_count_o !== e.count) begin
            $error("ack_count exp %0d got %0d", e.count, ack_count_o); fail_count++;
          end
          if (file_id_o !== e.id) begin
            $error("file_id exp %0h got %0h", e.id, file_id_o); fail_count++;
          end
          if (ack_crc_o !== e.crc) begin
            $error("ack_crc exp %0h got %0h", e.crc, ack_crc_o); fail_count++;
          end
          if (status_o !== e.status) begin
            $error("status exp %0b got %0b", e.status, status_o); fail_count++;
          end
          if (file_complete_o !== e.complete) begin
            $error("file_complete exp %0b got %0b", e.complete, file_complete_o);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        if (pos < drt_pkg::MAX_DATAGRAM) begin
          crc = crc32c_step(crc, data_byte_i);
          if (pos < 4) h_seq[8*pos +: 8] = data_byte_i;
          else if (pos < 8) h_total[8*(pos-4) +: 8] = data_byte_i;
          else if (pos == 8) h_type = data_byte_i;
          else if (pos < 17) h_id[8*(pos-9) +: 8] = data_byte_i;
          pos++;
        end
        if (last_byte_i) begin
          close_datagram();
          pos = 0;
          crc = '1;
        end
      end
      if (cfg_we_i) put_code <= cfg_wdata_i;
    end
    pending_acks = ack_q.size();
  end
endmodule

FILE: tb/datagram_reassembly_tracker_tb.sv
`timescale 1ns / 100ps

module datagram_reassembly_tracker_tb;
  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        push, full, empty, pop;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic [31:0] ack_seq_o, ack_crc_o;
  logic [10:0] ack_count_o;
  logic [63:0] file_id_o;
  logic        status_o, file_complete_o;
  int          fail_count, pending_acks;
  int          send_idle, recv_stall, quiet_cycles;
  logic [7:0]  put_code;
  logic [63:0] id_pool[8];
  logic [31:0] total_pool[8];

  datagram_reassembly_tracker uut (.*);
  datagram_reassembly_tracker_checker chk (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver side: random stalls on pop.
  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_stall);

  // Watchdog over cycles with no accepted request on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called at a falling edge; full is stable until the next rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    push = 1;
    data_byte_i = b;
    last_byte_i = last;
    while (full) @(negedge clk_i);
    @(negedge clk_i);
    push = 0;
  endtask

  // Sends a datagram of len bytes in all: header fields, then random bytes (len may be short).
  task automatic send_datagram(input logic [31:0] seq, input logic [31:0] total,
                               input logic [7:0] ptype, input logic [63:0] id,
                               input int len);
    logic [7:0] hdr[17];
    for (int i = 0; i < 4; i++) begin
      hdr[i] = seq[8*i +: 8];
      hdr[4+i] = total[8*i +: 8];
    end
    hdr[8] = ptype;
    for (int i = 0; i < 8; i++) hdr[9+i] = id[8*i +: 8];
    for (int i = 0; i < len; i++)
      send_byte(i < 17 ? hdr[i] : 8'($urandom), i == len - 1);
  endtask

  task automatic drain();
    while (pending_acks != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_put_code(input logic [7:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    put_code = v;
  endtask

  initial begin
    int n;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    push = 0;
    data_byte_i = 0;
    last_byte_i = 0;
    send_idle = 0;
    recv_stall = 0;
    quiet_cycles = 0;
    put_code = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: reset code 0, extremes and each special case.
    send_datagram(0, 1, 8'd0, 64'd0, 17);                   // completes at once
    send_datagram(1023, 2, 8'd0, '1, 17);
    send_datagram(1023, 2, 8'd0, '1, 20);                   // repeated sequence
    send_datagram(5, 3, 8'd0, '1, 18);                      // total mismatch
    send_datagram(1024, 2, 8'd0, 64'd7, 17);                // sequence out of range
    send_datagram('1, '1, 8'd0, 64'd7, 17);
    send_datagram(2, 2, 8'd1, 64'd7, 17);                   // wrong type
    send_datagram(2, 2, 8'd0, 64'd7, 16);                   // short datagram
    send_datagram(0, 0, 8'd0, 64'd9, 1);
    send_datagram(7, 9, 8'd0, 64'h55AA, 2100);              // oversize datagram
    write_put_code(8'hFF);
    send_datagram(0, '1, 8'hFF, 64'h8000_0000_0000_0000, 17);
    send_datagram(1, 2, 8'd0, 64'd3, 17);                   // old code now wrong
    for (int i = 0; i < 16; i++)                            // fill the table
      send_datagram(i, 4, 8'hFF, 64'h1000 + i, 17);
    send_datagram(3, 4, 8'hFF, 64'hDEAD, 17);               // table full
    write_put_code(8'h2A);

    // Random phases; the table is full, so only half of the pool ids are tracked.
    for (int i = 0; i < 8; i++) begin
      id_pool[i] = (i < 4) ? 64'h1000 + i : {$urandom, $urandom};
      total_pool[i] = 4;
    end
    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle = 76; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 76; end
        3: begin send_idle = 28; recv_stall = 28; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 2) write_put_code(8'($urandom));
      if (ph == 4) write_put_code(8'h00);
      for (int k = 0; k < 10; k++) begin
        int r, sel;
        r = $urandom_range(99);
        sel = $urandom_range(7);
        if (r < 80)
          send_datagram($urandom_range(5), r < 72 ? total_pool[sel] : $urandom_range(6),
                        put_code, id_pool[sel], $urandom_range(17, 24));
        else if (r < 90)
          send_datagram($urandom, $urandom, 8'($urandom), {$urandom, $urandom},
                        $urandom_range(1, 20));
        else
          send_datagram($urandom_range(1023), 4, put_code, id_pool[sel],
                        $urandom_range(1, 17));
        n++;
      end
      if (ph == 1) drain();
    end
    drain();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
